[src/wiwm_pkg.sv]
// ----------------------------------------------------------------------------
// wiwm_pkg
// Shared types and constants of the wrapped interval window median block.
// ----------------------------------------------------------------------------
package wiwm_pkg;

    localparam int TICK_W = 64;
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 7;

    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [CNT_W-1:0]  cnt_out_t;
    typedef logic [CFG_W-1:0]  cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RANK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic rotate;
    } cell_ctl_t;

    function automatic tick_t mask_from_bits(input cfg_t bits);
        tick_t m;
        m = '0;
        if (bits == '0)
        begin
            m = '0;
        end
        else if (bits >= cfg_t'(TICK_W))
        begin
            m = '1;
        end
        else
        begin
            m = (tick_t'(1) << bits) - tick_t'(1);
        end
        return m;
    endfunction

endpackage

[src/wiwm_in_if.sv]
// ----------------------------------------------------------------------------
// wiwm_in_if
// Input channel: one beat carries a start and an end timestamp.
// ----------------------------------------------------------------------------
interface wiwm_in_if;
    import wiwm_pkg::*;

    logic  valid;
    logic  ready;
    tick_t start_ticks;
    tick_t end_ticks;

    modport source (output valid, output start_ticks, output end_ticks, input ready);
    modport sink   (input valid, input start_ticks, input end_ticks, output ready);
endinterface

[src/wiwm_out_if.sv]
// ----------------------------------------------------------------------------
// wiwm_out_if
// Result channel: one beat carries the window median and the sample count.
// ----------------------------------------------------------------------------
interface wiwm_out_if;
    import wiwm_pkg::*;

    logic     valid;
    logic     ready;
    tick_t    median_ticks;
    cnt_out_t sample_count;

    modport source (output valid, output median_ticks, output sample_count, input ready);
    modport sink   (input valid, input median_ticks, input sample_count, output ready);
endinterface

[src/wiwm_cell.sv]
// ----------------------------------------------------------------------------
// wiwm_cell
// One window slot: holds a sample, passes it to its neighbor during ranking
// and counts how many held samples fall below and equal to its candidate.
// ----------------------------------------------------------------------------
module wiwm_cell #(
    parameter int WINDOW = 31,
    parameter int IDX    = 0
) (
    input  logic                        clk,
    input  wiwm_pkg::cell_ctl_t         ctl,
    input  logic                        wr_en,
    input  wiwm_pkg::tick_t             wr_data,
    input  wiwm_pkg::tick_t             nbr_smp,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] nbr_tag,
    input  logic [$clog2(WINDOW+1)-1:0] held,
    input  logic [$clog2(WINDOW+1)-1:0] half,
    output wiwm_pkg::tick_t             smp,
    output logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] tag,
    output wiwm_pkg::tick_t             cand,
    output logic                        match
);
    import wiwm_pkg::*;

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    tick_t         smp_reg, smp_next;
    tick_t         cand_reg, cand_next;
    logic [PW-1:0] tag_reg, tag_next;
    logic [CW-1:0] less_reg, less_next;
    logic [CW-1:0] eq_reg, eq_next;
    logic          pass_vld;
    logic          cand_vld;
    logic [CW:0]   upper;

    assign pass_vld = ({1'b0, tag_reg} < (PW+1)'(held));
    assign cand_vld = (CW'(IDX) < held);
    assign upper    = {1'b0, less_reg} + {1'b0, eq_reg};

    always_comb
    begin
        smp_next  = smp_reg;
        cand_next = cand_reg;
        tag_next  = tag_reg;
        less_next = less_reg;
        eq_next   = eq_reg;
        if (wr_en)
        begin
            smp_next = wr_data;
        end
        else if (ctl.load)
        begin
            cand_next = smp_reg;
            tag_next  = PW'(IDX);
            less_next = '0;
            eq_next   = '0;
        end
        else if (ctl.rotate)
        begin
            smp_next = nbr_smp;
            tag_next = nbr_tag;
            if (pass_vld && (smp_reg < cand_reg))
            begin
                less_next = less_reg + CW'(1);
            end
            if (pass_vld && (smp_reg == cand_reg))
            begin
                eq_next = eq_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        cand_reg <= cand_next;
        tag_reg  <= tag_next;
        less_reg <= less_next;
        eq_reg   <= eq_next;
    end

    assign smp   = smp_reg;
    assign tag   = tag_reg;
    assign cand  = cand_reg;
    assign match = cand_vld && (less_reg <= half) && ({1'b0, half} < upper);

endmodule

[src/wrapped_interval_window_median_top.sv]
// ----------------------------------------------------------------------------
// wrapped_interval_window_median_top
// Sliding-window median of wrapped timestamp intervals.
//
// in_ch carries start_ticks and end_ticks; each beat yields exactly one
// out_ch beat with the median of the held intervals (upper middle when the
// count is even) and the number of held samples. cfg_wr_en/cfg_wr_data set
// valid_bits, which masks both timestamps before the wrapped subtraction;
// write it only while the block is idle.
// The result is registered after the input beat passes through load, the
// ranking rotation and select. One item is in flight at a time, so no new
// input beat is taken until the current one has gone through one full
// rotation of the cell ring, one slot per cycle, and reached select.
// A finished result waits in the output register; the next input beat is
// taken meanwhile, and a new result waits in select until the register frees.
// Reset empties the window, points the write slot at zero and sets
// valid_bits to 64. No clearing pass is needed.
// ----------------------------------------------------------------------------
module wrapped_interval_window_median_top #(
    parameter int WINDOW = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  wiwm_pkg::cfg_t      cfg_wr_data,
    wiwm_in_if.sink             in_ch,
    wiwm_out_if.source          out_ch
);
    import wiwm_pkg::*;

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    state_t        state_reg, state_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [CW-1:0] held_reg, held_next;
    logic [PW-1:0] step_reg, step_next;
    tick_t         mask_reg;
    logic          out_vld_reg, out_vld_next;
    tick_t         out_med_reg, out_med_next;
    cnt_out_t      out_cnt_reg, out_cnt_next;

    cell_ctl_t     ctl;
    logic          in_acc;
    tick_t         interval;
    logic [CW-1:0] half;
    tick_t         med_sel;

    tick_t         smp_w  [WINDOW];
    logic [PW-1:0] tag_w  [WINDOW];
    tick_t         cand_w [WINDOW];
    logic [WINDOW-1:0] match_w;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign interval    = ((in_ch.end_ticks & mask_reg) - (in_ch.start_ticks & mask_reg))
                         & mask_reg;
    assign half        = held_reg >> 1;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            localparam int NB = (gi + 1) % WINDOW;
            wiwm_cell #(
                .WINDOW (WINDOW),
                .IDX    (gi)
            ) u_cell (
                .clk     (clk),
                .ctl     (ctl),
                .wr_en   (in_acc && (wp_reg == PW'(gi))),
                .wr_data (interval),
                .nbr_smp (smp_w[NB]),
                .nbr_tag (tag_w[NB]),
                .held    (held_reg),
                .half    (half),
                .smp     (smp_w[gi]),
                .tag     (tag_w[gi]),
                .cand    (cand_w[gi]),
                .match   (match_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        med_sel = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (match_w[i])
            begin
                med_sel = med_sel | cand_w[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RANK;
            end
            ST_RANK:
            begin
                if (step_reg == PW'(WINDOW - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_vld_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl          = '0;
        wp_next      = wp_reg;
        held_next    = held_reg;
        step_next    = step_reg;
        out_vld_next = out_vld_reg && !out_ch.ready;
        out_med_next = out_med_reg;
        out_cnt_next = out_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    wp_next = (wp_reg == PW'(WINDOW - 1)) ? '0 : wp_reg + PW'(1);
                    if (held_reg != CW'(WINDOW))
                    begin
                        held_next = held_reg + CW'(1);
                    end
                end
            end
            ST_LOAD:
            begin
                ctl.load  = 1'b1;
                step_next = '0;
            end
            ST_RANK:
            begin
                ctl.rotate = 1'b1;
                step_next  = step_reg + PW'(1);
            end
            ST_DONE:
            begin
                if (!out_vld_reg || out_ch.ready)
                begin
                    out_vld_next = 1'b1;
                    out_med_next = med_sel;
                    out_cnt_next = CNT_W'(held_reg);
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            held_reg    <= '0;
            step_reg    <= '0;
            mask_reg    <= '1;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            held_reg    <= held_next;
            step_reg    <= step_next;
            out_vld_reg <= out_vld_next;
            if (cfg_wr_en)
            begin
                mask_reg <= mask_from_bits(cfg_wr_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_med_reg <= out_med_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.median_ticks = out_med_reg;
    assign out_ch.sample_count = out_cnt_reg;

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(WINDOW))
        else $error("held count beyond window");

    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, wp_reg} < (PW+1)'(WINDOW))
        else $error("write slot beyond window");

    a_median_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> match_w != '0)
        else $error("no cell holds the median");

    a_result_from_select: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside select");

    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> held_reg != '0)
        else $error("result with empty window");

endmodule

[dv/wiwm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wiwm_checker
// Watches the config port and both channels of the wrapped interval window
// median block. Each accepted input beat is masked, differenced and pushed
// into a local window; the window median and sample count are queued and
// compared field by field with each accepted result beat.
// ----------------------------------------------------------------------------
module wiwm_checker #(
    parameter int WINDOW = 31
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  wiwm_pkg::cfg_t cfg_wr_data,
    wiwm_in_if             in_ch,
    wiwm_out_if            out_ch,
    output int             fail_count,
    output int             pending
);
    import wiwm_pkg::*;

    typedef struct packed {
        tick_t    median_ticks;
        cnt_out_t sample_count;
    } median_beat_t;

    median_beat_t median_q[$];
    median_beat_t want;
    tick_t        interval_ring [WINDOW];
    int unsigned  next_slot;
    int unsigned  held;
    cfg_t         width_bits;
    tick_t        span_mask;
    tick_t        span;

    function automatic tick_t span_mask_of(input cfg_t bits);
        if (bits == '0)
        begin
            return '0;
        end
        if (int'(bits) >= TICK_W)
        begin
            return '1;
        end
        return ~(~tick_t'(0) << bits);
    endfunction

    function automatic tick_t window_median(input int unsigned n);
        tick_t       sorted [WINDOW];
        tick_t       v;
        int unsigned j;
        for (int unsigned i = 0; i < n; i++)
        begin
            sorted[i] = interval_ring[i];
        end
        for (int unsigned i = 1; i < n; i++)
        begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[n/2];
    endfunction

    initial
    begin
        fail_count = 0;
        pending    = 0;
        next_slot  = 0;
        held       = 0;
        width_bits = cfg_t'(TICK_W);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_slot  = 0;
            held       = 0;
            width_bits = cfg_t'(TICK_W);
            median_q.delete();
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                width_bits = cfg_wr_data;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                span_mask = span_mask_of(width_bits);
                span = ((in_ch.end_ticks & span_mask) - (in_ch.start_ticks & span_mask))
                       & span_mask;
                interval_ring[next_slot] = span;
                next_slot = (next_slot + 1) % WINDOW;
                if (held < WINDOW)
                begin
                    held++;
                end
                want.median_ticks = window_median(held);
                want.sample_count = cnt_out_t'(held);
                median_q.push_back(want);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (median_q.size() == 0)
                begin
                    $error("unexpected result beat: median_ticks %0h sample_count %0d",
                           out_ch.median_ticks, out_ch.sample_count);
                    fail_count++;
                end
                else
                begin
                    want = median_q.pop_front();
                    if (out_ch.median_ticks !== want.median_ticks)
                    begin
                        $error("median_ticks: expected %0h, actual %0h",
                               want.median_ticks, out_ch.median_ticks);
                        fail_count++;
                    end
                    if (out_ch.sample_count !== want.sample_count)
                    begin
                        $error("sample_count: expected %0d, actual %0d",
                               want.sample_count, out_ch.sample_count);
                        fail_count++;
                    end
                end
            end
            pending = median_q.size();
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the wrapped interval window median block. Runs a
// short directed set over mask widths and timestamp extremes, then random
// phases under several valid_bits settings and idle patterns on both sides;
// the checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
    import wiwm_pkg::*;

    localparam int WINDOW       = 31;
    localparam int PHASE_ITEMS  = 123;
    localparam int DRAIN_CYCLES = WINDOW + 8;
    localparam int PHASES       = 9;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    cfg_t cfg_wr_data;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   fail_count;
    int   pending;

    cfg_t phase_bits [PHASES-1] = '{7'd64, 7'd1, 7'd32, 7'd0, 7'd127, 7'd2, 7'd63, 7'd65};

    wiwm_in_if  in_ch ();
    wiwm_out_if out_ch ();

    wrapped_interval_window_median_top #(
        .WINDOW (WINDOW)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    wiwm_checker #(
        .WINDOW (WINDOW)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic tick_t rand_ticks();
        return {$urandom, $urandom};
    endfunction

    task automatic send_interval(input tick_t s, input tick_t e);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.start_ticks <= s;
        in_ch.end_ticks   <= e;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_valid_bits(input cfg_t bits);
        in_ch.valid <= 1'b0;
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bits;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic next_interval(output tick_t s, output tick_t e);
        case ($urandom_range(0, 4))
            0:
            begin
                s = rand_ticks();
                e = rand_ticks();
            end
            1:
            begin
                s = rand_ticks();
                e = s + tick_t'($urandom_range(0, 1000));
            end
            2:
            begin
                s = ~tick_t'(0) - tick_t'($urandom_range(0, 500));
                e = tick_t'($urandom_range(0, 500));
            end
            3:
            begin
                s = tick_t'($urandom_range(0, 7));
                e = tick_t'($urandom_range(0, 7));
            end
            default:
            begin
                s = $urandom_range(0, 1) ? ~tick_t'(0) : tick_t'(0);
                e = $urandom_range(0, 1) ? ~tick_t'(0) : tick_t'(0);
            end
        endcase
    endtask

    initial
    begin
        #20_000_000;
        $display("** wrapped_interval_window_median_top: FAILED **");
        $finish;
    end

    initial
    begin
        tick_t s;
        tick_t e;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        in_ch.valid       = 1'b0;
        in_ch.start_ticks = '0;
        in_ch.end_ticks   = '0;
        out_ch.ready      = 1'b0;
        tx_idle_pct       = 11;
        rx_idle_pct       = 66;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        send_interval(64'h0, 64'h0);
        send_interval(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_interval(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_interval(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_interval(64'h5, 64'h3);
        send_interval(64'h3, 64'h5);
        send_interval(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_interval(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);

        write_valid_bits(7'd0);
        send_interval(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_interval(64'hFFFF_FFFF_FFFF_FFFF, 64'h5A5A_A5A5_5A5A_A5A5);

        write_valid_bits(7'd1);
        send_interval(64'h0, 64'h1);
        send_interval(64'h1, 64'h0);
        send_interval(64'h3, 64'h2);

        write_valid_bits(7'd127);
        send_interval(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_interval(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);

        write_valid_bits(7'd65);
        send_interval(64'h2, 64'h1);

        write_valid_bits(7'd63);
        send_interval(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
        send_interval(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < PHASES - 1)
            begin
                write_valid_bits(phase_bits[p]);
            end
            else
            begin
                write_valid_bits(cfg_t'($urandom_range(0, 127)));
            end
            tx_idle_pct = (p < 3) ? 11 : ((p < 6) ? 66 : 0);
            rx_idle_pct = (p < 3) ? 66 : ((p < 6) ? 11 : 0);
            repeat (PHASE_ITEMS)
            begin
                next_interval(s, e);
                send_interval(s, e);
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("** wrapped_interval_window_median_top: PASSED **");
        end
        else
        begin
            $display("** wrapped_interval_window_median_top: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
src/wiwm_pkg.sv
src/wiwm_in_if.sv
src/wiwm_out_if.sv
src/wiwm_cell.sv
src/wrapped_interval_window_median_top.sv
dv/wiwm_checker.sv
dv/testbench.sv
